[design/pbpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpg_pkg
// Shared types, constants and tone tables for the beep pattern generator.
// ----------------------------------------------------------------------------
package pbpg_pkg;

   localparam int TIME_BITS_DEF = 48;
   localparam int DIV_W         = 21;   // widest modulus 1200000 < 2^21
   localparam int STEP_W        = 6;    // divider step count, up to 63
   localparam int CM_W          = 10;
   localparam int FREQ_W        = 12;
   localparam int DUR_W         = 18;

   localparam logic [CM_W-1:0]   CM_MAX    = CM_W'(999);
   localparam logic [FREQ_W-1:0] IDLE_FREQ = FREQ_W'(2000);
   localparam logic [15:0]       MM_LIMIT  = 16'd300;
   // n / 10 == (n * 52429) >> 19 for n < 32768
   localparam logic [15:0]       RECIP10   = 16'd52429;
   localparam int                RECIP_SH  = 19;

   localparam logic [DIV_W-1:0] ERR_PERIOD  = DIV_W'(1200000);
   localparam logic [DIV_W-1:0] DIR_PERIOD  = DIV_W'(600000);
   localparam logic [DIV_W-1:0] DIR_CLEAR   = DIV_W'(599000);
   localparam logic [DIV_W-1:0] MS_100      = DIV_W'(100000);
   localparam logic [DIV_W-1:0] MS_200      = DIV_W'(200000);
   localparam logic [DIV_W-1:0] MS_300      = DIV_W'(300000);
   localparam logic [DIV_W-1:0] MS_400      = DIV_W'(400000);
   localparam logic [DIV_W-1:0] MS_500      = DIV_W'(500000);
   localparam logic [DIV_W-1:0] MS_80       = DIV_W'(80000);
   localparam logic [DIV_W-1:0] MS_160      = DIV_W'(160000);
   localparam logic [DIV_W-1:0] MS_240      = DIV_W'(240000);
   localparam logic [DIV_W-1:0] MS_60       = DIV_W'(60000);
   localparam logic [DIV_W-1:0] NEAR_PERIOD = DIV_W'(150000);
   localparam logic [DIV_W-1:0] FAR_PERIOD  = DIV_W'(1000000);

   localparam logic [CM_W-1:0] CM_NEAR = CM_W'(30);
   localparam logic [CM_W-1:0] CM_FAR  = CM_W'(150);
   localparam logic [9:0]      SLOPE   = 10'd850;
   localparam logic [DIV_W-1:0] SLOPE_DEN = DIV_W'(120);
   localparam int              PDIV_BITS = 17;   // 850 * 119 < 2^17
   localparam logic [10:0]     PERIOD_BASE = 11'd150;
   localparam logic [9:0]      US_PER_MS   = 10'd1000;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_ONE  = 3'd1;
   localparam logic [2:0] EV_TWO  = 3'd2;
   localparam logic [2:0] EV_THREE = 3'd3;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [FREQ_W-1:0] tone_freq(input logic [2:0] ev);
      logic [FREQ_W-1:0] f;
      case (ev)
         EV_ONE:   f = FREQ_W'(2500);
         EV_TWO:   f = FREQ_W'(1200);
         EV_THREE: f = FREQ_W'(1800);
         default:  f = IDLE_FREQ;
      endcase
      return f;
   endfunction

   function automatic logic [DUR_W-1:0] tone_dur_us(input logic [2:0] ev);
      logic [DUR_W-1:0] d;
      case (ev)
         EV_ONE:  d = DUR_W'(150000);
         EV_TWO:  d = DUR_W'(180000);
         default: d = DUR_W'(120000);
      endcase
      return d;
   endfunction

endpackage

[design/pbpg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpg_req_if / pbpg_rsp_if
// Valid/ready channels for service call items and buzzer result items.
// ----------------------------------------------------------------------------
interface pbpg_req_if
   import pbpg_pkg::*;
#(parameter int TIME_BITS = TIME_BITS_DEF);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] now_us;
   logic                 error_flag;
   logic [2:0]           event_id;
   logic signed [1:0]    direction;
   logic signed [15:0]   range_raw;
   logic                 distance_valid;

   modport source (output valid, now_us, error_flag, event_id, direction,
                   range_raw, distance_valid, input ready);
   modport sink   (input valid, now_us, error_flag, event_id, direction,
                   range_raw, distance_valid, output ready);
endinterface

interface pbpg_rsp_if;
   logic        valid;
   logic        ready;
   logic        active_on;
   logic        passive_on;
   logic [11:0] passive_freq_hz;

   modport source (output valid, active_on, passive_on, passive_freq_hz,
                   input ready);
   modport sink   (input valid, active_on, passive_on, passive_freq_hz,
                   output ready);
endinterface

[design/pbpg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpg_div
// Restoring divider, one quotient bit per cycle, MSB of numerator first.
// ----------------------------------------------------------------------------
module pbpg_div
   import pbpg_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         ctrl,
   input  logic [TIME_BITS-1:0] numer,
   input  logic [DIV_W-1:0]     divisor,
   output div_stat_type         stat,
   output logic [TIME_BITS-1:0] quot,
   output logic [DIV_W-1:0]     rem
);

   logic [TIME_BITS-1:0] num_ff, num_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       partial;
   logic                 fits;

   assign partial = {rem_ff, num_ff[TIME_BITS-1]};
   assign fits    = partial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         num_in  = numer;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(partial - {1'b0, den_ff}) : partial[DIV_W-1:0];
         num_in = {num_ff[TIME_BITS-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = num_ff;
   assign rem       = rem_ff;

endmodule

[design/proximity_beep_pattern_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_beep_pattern_generator_top
// Buzzer pattern generator: one service call item in, one buzzer item out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_bus   in   valid/ready   now_us, error_flag, event_id, direction,
//                               range_raw, distance_valid
//  rsp_bus   out  valid/ready   active_on, passive_on, passive_freq_hz
//
//  Divider: an item runs the shared bit-serial divider (time modulo pattern
//  period); a distance in the 31..149 cm band first adds a period division
//  in the same divider. A steady tone (1..29 cm, valid distance, no error
//  or cue) skips the divider.
//  Reset: synchronous, active high; all buzzer state returns to idle values.
//  Stalls: req_ready is high only while the sequencer is idle; a finished
//  result waits in the output register, and the next item can be taken
//  while it waits.
// ----------------------------------------------------------------------------
module proximity_beep_pattern_generator_top
   import pbpg_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pbpg_req_if.sink      req_bus,
   pbpg_rsp_if.source    rsp_bus
);

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_STOP, S_PDIV, S_MOD, S_DONE
   } state_type;

   // which waveform the modulus result feeds
   typedef enum logic [1:0] {
      M_ERR, M_LEFT, M_RIGHT, M_DIST
   } mode_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;

   // latched item
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 err_ff, err_in;
   logic signed [15:0]   dv_ff, dv_in;

   // buzzer state
   logic                 active_ff, active_in;
   logic                 plevel_ff, plevel_in;
   logic [TIME_BITS-1:0] pend_ff, pend_in;       // tone end time
   logic [FREQ_W-1:0]    pfreq_ff, pfreq_in;
   logic [2:0]           pevent_ff, pevent_in;
   logic signed [1:0]    dir_ff, dir_in;
   logic [CM_W-1:0]      cm_ff, cm_in;
   logic                 dok_ff, dok_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_act_ff, rsp_act_in;
   logic                 rsp_pas_ff, rsp_pas_in;
   logic [FREQ_W-1:0]    rsp_freq_ff, rsp_freq_in;

   // divider hookup
   div_ctrl_type         dctrl;
   div_stat_type         dstat;
   logic [TIME_BITS-1:0] dnumer;
   logic [DIV_W-1:0]     ddivisor;
   logic [TIME_BITS-1:0] dquot;
   logic [DIV_W-1:0]     drem;

   // distance conversion helpers
   logic [30:0]          mm_prod;
   logic [11:0]          mm_cm;
   logic [16:0]          slope_num;
   logic [10:0]          period_ms;
   logic [DIV_W-1:0]     cycle_len_us;
   logic                 accept;
   logic                 out_free;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign mm_prod      = 31'(dv_ff[14:0]) * 31'(RECIP10);
   assign mm_cm        = mm_prod[RECIP_SH +: 12];
   assign slope_num    = 17'(cm_ff - CM_NEAR) * 17'(SLOPE);
   assign period_ms    = PERIOD_BASE + 11'(dquot[9:0]);
   assign cycle_len_us = DIV_W'(period_ms) * DIV_W'(US_PER_MS);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      err_in       = err_ff;
      dv_in        = dv_ff;
      active_in    = active_ff;
      plevel_in    = plevel_ff;
      pend_in      = pend_ff;
      pfreq_in     = pfreq_ff;
      pevent_in    = pevent_ff;
      dir_in       = dir_ff;
      cm_in        = cm_ff;
      dok_in       = dok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_act_in   = rsp_act_ff;
      rsp_pas_in   = rsp_pas_ff;
      rsp_freq_in  = rsp_freq_ff;
      dctrl.start  = 1'b0;
      dctrl.steps  = STEP_W'(TIME_BITS);
      dnumer       = now_ff;
      ddivisor     = ERR_PERIOD;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in = req_bus.now_us;
               err_in = req_bus.error_flag;
               dv_in  = req_bus.range_raw;
               dok_in = req_bus.distance_valid;
               if (req_bus.event_id != EV_NONE) begin
                  pevent_in = req_bus.event_id;
               end
               if (req_bus.direction != 2'sd0) begin
                  dir_in = req_bus.direction;
               end
               state_in = S_PREP;
            end
         end

         S_PREP: begin
            // centimetres, clamped to 0..999; above 300 the value is mm
            if (dv_ff > 16'sd300) begin
               cm_in = (mm_cm > 12'(CM_MAX)) ? CM_MAX : mm_cm[CM_W-1:0];
            end else if (dv_ff < 16'sd0) begin
               cm_in = '0;
            end else begin
               cm_in = dv_ff[CM_W-1:0];
            end
            // one-shot tone start once no earlier tone is still due
            if (pevent_ff != EV_NONE && !(pend_ff > now_ff)) begin
               plevel_in = 1'b1;
               pfreq_in  = tone_freq(pevent_ff);
               pend_in   = now_ff + TIME_BITS'(tone_dur_us(pevent_ff));
               pevent_in = EV_NONE;
            end
            state_in = S_STOP;
         end

         S_STOP: begin
            // an end time of zero never stops a tone
            if (plevel_ff && pend_ff != '0 && now_ff >= pend_ff) begin
               plevel_in = 1'b0;
               pfreq_in  = IDLE_FREQ;
               pend_in   = '0;
            end
            // priority: error, direction cue, invalid distance (error pattern), distance warning
            state_in = S_MOD;
            if (err_ff) begin
               mode_in     = M_ERR;
               dctrl.start = 1'b1;
               ddivisor    = ERR_PERIOD;
            end else if (dir_ff != 2'sd0) begin
               mode_in     = dir_ff[1] ? M_LEFT : M_RIGHT;
               dctrl.start = 1'b1;
               ddivisor    = DIR_PERIOD;
            end else if (!dok_ff) begin
               mode_in     = M_ERR;
               dctrl.start = 1'b1;
               ddivisor    = ERR_PERIOD;
            end else if (cm_ff != '0 && cm_ff < CM_NEAR) begin
               active_in = 1'b1;
               state_in  = S_DONE;
            end else if (cm_ff >= CM_FAR) begin
               mode_in     = M_DIST;
               dctrl.start = 1'b1;
               ddivisor    = FAR_PERIOD;
            end else if (cm_ff <= CM_NEAR) begin
               mode_in     = M_DIST;
               dctrl.start = 1'b1;
               ddivisor    = NEAR_PERIOD;
            end else begin
               // period slope 850*(cm-30)/120 through the same divider
               mode_in     = M_DIST;
               dctrl.start = 1'b1;
               dctrl.steps = STEP_W'(PDIV_BITS);
               dnumer      = TIME_BITS'(slope_num) << (TIME_BITS - PDIV_BITS);
               ddivisor    = SLOPE_DEN;
               state_in    = S_PDIV;
            end
         end

         S_PDIV: begin
            if (dstat.done) begin
               dctrl.start = 1'b1;
               ddivisor    = cycle_len_us;
               state_in    = S_MOD;
            end
         end

         S_MOD: begin
            if (dstat.done) begin
               case (mode_ff)
                  M_ERR: begin
                     active_in = (drem < MS_100) ||
                                 (drem >= MS_200 && drem < MS_300) ||
                                 (drem >= MS_400 && drem < MS_500);
                  end
                  M_LEFT: begin
                     active_in = (drem < MS_80) || (drem >= MS_160 && drem < MS_240);
                  end
                  M_RIGHT: begin
                     active_in = drem < MS_200;
                  end
                  default: begin
                     active_in = drem < MS_60;
                  end
               endcase
               // cue clears itself at the end of its period
               if ((mode_ff == M_LEFT || mode_ff == M_RIGHT) && drem >= DIR_CLEAR) begin
                  dir_in = 2'sd0;
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = active_ff;
               rsp_pas_in   = plevel_ff;
               rsp_freq_in  = pfreq_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_ERR;
         active_ff    <= 1'b0;
         plevel_ff    <= 1'b0;
         pend_ff      <= '0;
         pfreq_ff     <= IDLE_FREQ;
         pevent_ff    <= EV_NONE;
         dir_ff       <= 2'sd0;
         cm_ff        <= CM_MAX;
         dok_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         active_ff    <= active_in;
         plevel_ff    <= plevel_in;
         pend_ff      <= pend_in;
         pfreq_ff     <= pfreq_in;
         pevent_ff    <= pevent_in;
         dir_ff       <= dir_in;
         cm_ff        <= cm_in;
         dok_ff       <= dok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      err_ff      <= err_in;
      dv_ff       <= dv_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_pas_ff  <= rsp_pas_in;
      rsp_freq_ff <= rsp_freq_in;
   end

   pbpg_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (dctrl),
      .numer   (dnumer),
      .divisor (ddivisor),
      .stat    (dstat),
      .quot    (dquot),
      .rem     (drem)
   );

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.active_on       = rsp_act_ff;
   assign rsp_bus.passive_on      = rsp_pas_ff;
   assign rsp_bus.passive_freq_hz = rsp_freq_ff;

endmodule
